// ===== design/lkvc_pkg.sv =====
// Package for the LRU key-value cache: sizes, request/result/entry types
// and the controller state encoding. No dependencies.
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int AGE_W   = IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int EW      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [EW-1:0]    ENTRIES_E = EW'(ENTRIES);

  localparam logic signed [31:0] MISS_VALUE = -32'sd1;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic [31:0]      key;
    logic [31:0]      value;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SDRAIN,
    ST_DECIDE,
    ST_UPD,
    ST_UDRAIN,
    ST_FINISH
  } state_t;

endpackage

// ===== design/lru_key_value_cache.sv =====
// LRU key-value cache, fully associative, one entry memory with per-entry ages.
// Depends on lkvc_pkg.
//
// Usage:
//   in_valid/in_ready carry one request (get or put with key and value).
//   out_valid/out_ready carry one result per request: hit flag and read value
//   (stored value on a get hit, -1 on a get miss, 0 on a put).
//   cfg_we/cfg_wdata write the capacity register (0 acts as 1, values above
//   the entry count act as the entry count); write it only while idle.
// Timing:
//   Requests are handled one at a time. Each request makes a lookup pass
//   over the single entry memory, reading one entry per cycle; every request
//   but a get that misses then makes a read-modify-write pass that ages
//   entries and writes the target entry.
//   in_ready rises in the same cycle as out_valid, so a new request is taken
//   while an old result still waits.
// Reset:
//   Synchronous, active low. Clears all valid bits, the fill count and the
//   handshake state; capacity returns to 16. The memory itself is not cleared.
// Stall:
//   If out_ready is low the result holds in the output register; a finished
//   request waits for the register to empty before loading its result.
module lru_key_value_cache (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  lkvc_pkg::req_t           in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output lkvc_pkg::rsp_t           out_data,
  input  logic                     cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata
);
  import lkvc_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rd_data_r;
  logic   mem_we;
  entry_t mem_wdata;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic               rv_r, rv_nxt;
  logic [IDX_W-1:0]   ridx_r, ridx_nxt;
  req_t               req_r, req_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CAP_W-1:0]   cap_r;

  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   hslot_r, hslot_nxt;
  logic [AGE_W-1:0]   hage_r, hage_nxt;
  logic [31:0]        hval_r, hval_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_r, free_nxt;
  logic               any_r, any_nxt;
  logic [IDX_W-1:0]   old_slot_r, old_slot_nxt;
  logic [AGE_W-1:0]   old_age_r, old_age_nxt;

  logic [IDX_W-1:0]   tgt_r, tgt_nxt;
  logic               touch_r, touch_nxt;
  rsp_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  rsp_t               out_data_r, out_data_nxt;

  logic [EW-1:0]      eff_cap;
  logic               rd_valid;

  // Capacity clamp to 1 .. ENTRIES
  always_comb begin
    eff_cap = EW'(cap_r);
    if (eff_cap == '0) begin
      eff_cap = EW'(1);
    end else if (eff_cap > ENTRIES_E) begin
      eff_cap = ENTRIES_E;
    end
  end

  assign rd_valid = valid_r[ridx_r];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ridx_r] <= mem_wdata;
    end
    rd_data_r <= mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rv_r        <= 1'b0;
      valid_r     <= '0;
      fill_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rv_r        <= rv_nxt;
      valid_r     <= valid_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    ridx_r       <= ridx_nxt;
    req_r        <= req_nxt;
    found_r      <= found_nxt;
    hslot_r      <= hslot_nxt;
    hage_r       <= hage_nxt;
    hval_r       <= hval_nxt;
    free_found_r <= free_found_nxt;
    free_r       <= free_nxt;
    any_r        <= any_nxt;
    old_slot_r   <= old_slot_nxt;
    old_age_r    <= old_age_nxt;
    tgt_r        <= tgt_nxt;
    touch_r      <= touch_nxt;
    res_r        <= res_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rv_nxt         = 1'b0;
    ridx_nxt       = cnt_r;
    req_nxt        = req_r;
    valid_nxt      = valid_r;
    fill_nxt       = fill_r;
    found_nxt      = found_r;
    hslot_nxt      = hslot_r;
    hage_nxt       = hage_r;
    hval_nxt       = hval_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    any_nxt        = any_r;
    old_slot_nxt   = old_slot_r;
    old_age_nxt    = old_age_r;
    tgt_nxt        = tgt_r;
    touch_nxt      = touch_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    in_ready       = 1'b0;
    mem_we         = 1'b0;
    mem_wdata      = rd_data_r;

    // Lookup pass: track first match, first free slot and oldest entry
    if (rv_r && (state_r == ST_SCAN || state_r == ST_SDRAIN)) begin
      if (!found_r && rd_valid && rd_data_r.key == req_r.key) begin
        found_nxt = 1'b1;
        hslot_nxt = ridx_r;
        hage_nxt  = rd_data_r.age;
        hval_nxt  = rd_data_r.value;
      end
      if (!free_found_r && !rd_valid) begin
        free_found_nxt = 1'b1;
        free_nxt       = ridx_r;
      end
      if (rd_valid && (!any_r || rd_data_r.age > old_age_r)) begin
        any_nxt      = 1'b1;
        old_slot_nxt = ridx_r;
        old_age_nxt  = rd_data_r.age;
      end
    end

    // Update pass: age entries, write the target entry
    if (rv_r && (state_r == ST_UPD || state_r == ST_UDRAIN)) begin
      if (ridx_r == tgt_r) begin
        mem_we        = 1'b1;
        mem_wdata.age = '0;
        if (req_r.opcode == OP_PUT) begin
          mem_wdata.value = req_r.value;
        end
        if (!found_r) begin
          mem_wdata.key = req_r.key;
        end
      end else if (rd_valid && (!touch_r || rd_data_r.age < hage_r)) begin
        mem_we        = 1'b1;
        mem_wdata.age = rd_data_r.age + AGE_W'(1);
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt        = in_data;
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          any_nxt        = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rv_nxt  = 1'b1;
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_SDRAIN;
        end
      end
      ST_SDRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        res_nxt.hit = found_r;
        if (req_r.opcode == OP_GET) begin
          res_nxt.read_value = found_r ? hval_r : MISS_VALUE;
        end else begin
          res_nxt.read_value = '0;
        end
        touch_nxt = found_r;
        cnt_nxt   = '0;
        state_nxt = ST_UPD;
        if (found_r) begin
          tgt_nxt = hslot_r;
        end else if (EW'(fill_r) < eff_cap && free_found_r) begin
          tgt_nxt  = free_r;
          fill_nxt = fill_r + CNT_W'(1);
        end else if (any_r) begin
          tgt_nxt = old_slot_r;
        end else begin
          tgt_nxt  = '0;
          fill_nxt = fill_r + CNT_W'(1);
        end
        if (req_r.opcode == OP_GET && !found_r) begin
          fill_nxt  = fill_r;
          state_nxt = ST_FINISH;
        end else if (!found_r) begin
          valid_nxt[tgt_nxt] = 1'b1;
        end
      end
      ST_UPD: begin
        rv_nxt  = 1'b1;
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_UDRAIN;
        end
      end
      ST_UDRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/lkvc_checker.sv =====
// Port-level checks for the LRU key-value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache.
module lkvc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input lkvc_pkg::rsp_t             out_data
);
  import lkvc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in flight: ready drops right after an accept
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while busy");

  // no result can appear the cycle after a request is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  // a miss yields -1 (get) or 0 (put)
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |->
      out_data.read_value == MISS_VALUE || out_data.read_value == 32'sd0)
    else $error("bad value on a miss");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);
